@@ rtl/core/lpf_pkg.sv @@
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared widths, constants, types and helpers for the leapfrog particle core.
// ----------------------------------------------------------------------------
package lpf_pkg;

    // Field widths
    localparam int AXES      = 3;
    localparam int AXIS_W    = 2;
    localparam int FIX_W     = 32;
    localparam int DT_W      = 16;
    localparam int KE_W      = 63;

    // Shared multiplier: signed 34 x 34
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 2 * MUL_W;

    // Divider: |dt * f| < 2^47, one quotient bit per cycle
    localparam int DIV_W     = 48;
    localparam int DIV_CNT_W = 6;

    // Saturation input width: 48 bit quotient plus sign plus carry
    localparam int SAT_IN_W  = 50;

    // Position term: floor(dt * v' / 2^16), product fits in 49 bits
    localparam int POS_SHIFT = 16;
    localparam int POS_MSB   = 48;
    localparam int POS_W     = POS_MSB - POS_SHIFT + 1;

    // Speed sum magnitude and its square
    localparam int MAG_W     = FIX_W + 1;
    localparam int SQ_PROD_W = 2 * MAG_W - 1;
    localparam int SQ_W      = 66;
    localparam int SQ_HALF   = 33;

    // Energy product mass * sum of squares, then >> 19 with saturation
    localparam int EPROD_W   = FIX_W + SQ_W;
    localparam int E_SHIFT   = 19;
    localparam int E_SAT_LSB = E_SHIFT + KE_W;

    localparam logic [DT_W-1:0]   TIME_STEP_RESET = DT_W'(131);
    localparam logic [KE_W-1:0]   KE_MAX          = {KE_W{1'b1}};
    localparam logic [AXIS_W-1:0] AXIS_LAST       = AXIS_W'(AXES - 1);

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DF,
        S_DIV_LD,
        S_DIV,
        S_VN,
        S_MUL_DV,
        S_POS,
        S_SQ,
        S_E_LO,
        S_E_HI,
        S_E_ACC,
        S_E_SUM,
        S_OUT
    } t_state;

    // Shared multiplier operand select
    typedef enum logic [2:0] {
        MS_DT_F,
        MS_DT_V,
        MS_MAG,
        MS_E_LO,
        MS_E_HI
    } t_mul_sel;

    // Datapath controls decoded from the sequencer state
    typedef struct packed {
        logic     in_ready;
        logic     div_start;
        t_mul_sel mul_sel;
        logic     ld_vn;
        logic     ld_mag;
        logic     ld_pos;
        logic     ld_sq;
        logic     ld_elo;
        logic     ld_eacc;
        logic     ld_esum;
        logic     ld_out;
    } t_ctrl;

    // Clamp a wide signed value to the signed 32 bit range
    function automatic logic signed [FIX_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] x);
        logic [SAT_IN_W-FIX_W:0] top;
        logic signed [FIX_W-1:0] res;
        top = x[SAT_IN_W-1:FIX_W-1];
        if ((&top) || !(|top)) begin
            res = x[FIX_W-1:0];
        end else if (x[SAT_IN_W-1]) begin
            res = {1'b1, {(FIX_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(FIX_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ rtl/core/lpf_in_if.sv @@
// ----------------------------------------------------------------------------
// lpf_in_if
// Particle input channel: valid/ready handshake with the particle payload.
// ----------------------------------------------------------------------------
interface lpf_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        mass;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic signed [31:0] position_z;
    logic               last_particle;

    modport source (
        output valid, mass, force_x, force_y, force_z,
               velocity_x, velocity_y, velocity_z,
               position_x, position_y, position_z, last_particle,
        input  ready
    );

    modport sink (
        input  valid, mass, force_x, force_y, force_z,
               velocity_x, velocity_y, velocity_z,
               position_x, position_y, position_z, last_particle,
        output ready
    );
endinterface

@@ rtl/core/lpf_out_if.sv @@
// ----------------------------------------------------------------------------
// lpf_out_if
// Result channel: valid/ready handshake with the updated particle payload.
// ----------------------------------------------------------------------------
interface lpf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_velocity_x;
    logic signed [31:0] new_velocity_y;
    logic signed [31:0] new_velocity_z;
    logic signed [31:0] new_position_x;
    logic signed [31:0] new_position_y;
    logic signed [31:0] new_position_z;
    logic [62:0]        kinetic_total;
    logic               end_of_system;

    modport source (
        output valid, new_velocity_x, new_velocity_y, new_velocity_z,
               new_position_x, new_position_y, new_position_z,
               kinetic_total, end_of_system,
        input  ready
    );

    modport sink (
        input  valid, new_velocity_x, new_velocity_y, new_velocity_z,
               new_position_x, new_position_y, new_position_z,
               kinetic_total, end_of_system,
        output ready
    );
endinterface

@@ rtl/core/lpf_div.sv @@
// ----------------------------------------------------------------------------
// lpf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpf_div
    import lpf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [FIX_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

    logic [FIX_W-1:0]     r_rem;
    logic [FIX_W-1:0]     n_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     n_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [FIX_W:0]       trial;
    logic [FIX_W+1:0]     diff;
    logic                 fits;

    // Trial subtract: shift in the next dividend bit, compare with divisor
    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        diff  = {1'b0, trial} - {2'b00, i_divisor};
        fits  = !diff[FIX_W+1];
        n_rem = fits ? diff[FIX_W-1:0] : trial[FIX_W-1:0];
        n_quo = {r_quo[DIV_W-2:0], fits};
    end

    // Step counter and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/core/lpf_mul.sv @@
// ----------------------------------------------------------------------------
// lpf_mul
// Shared signed 34 x 34 multiplier with a registered product.
// ----------------------------------------------------------------------------
module lpf_mul
    import lpf_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // One product per cycle, available the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/core/leapfrog_particle_update_core.sv @@
// ----------------------------------------------------------------------------
// leapfrog_particle_update_core
// Fixed point leapfrog update of one particle per item, with a running
// kinetic energy sum reported on the last particle of the system.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one particle per transfer (mass, force, half-step velocity,
//   position, last flag). o_out returns one result per particle: new velocity
//   and position per axis, plus the energy total and end flag on the last
//   particle. i_cfg_wr_en/i_cfg_wr_data write the 16 bit time step; write it
//   only while no particle is in flight.
// Sequence and acceptance:
//   Each axis forms dt*f in the shared multiplier, divides it by m in the 48
//   step shared divider, then uses the multiplier for dt*v' and |v+v'|^2 and
//   loads the update registers. The energy product then takes two more
//   multiplier passes before the result load. A new item is taken only after
//   the result is loaded into the output register; i_in.ready is high only when idle.
// Reset:
//   Synchronous, active low. Time step returns to 131, the energy sum to zero,
//   o_out.valid drops.
// Stall:
//   A result waits in the output register; the next particle is accepted and
//   processed meanwhile, and the core holds its next result until the register
//   is free.
// ----------------------------------------------------------------------------
module leapfrog_particle_update_core
    import lpf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [DT_W-1:0] i_cfg_wr_data,
    lpf_in_if.sink          i_in,
    lpf_out_if.source       o_out
);

    t_state r_state;
    t_state n_state;
    t_ctrl  ctrl;

    logic [DT_W-1:0]         r_time_step;
    logic [FIX_W-1:0]        r_mass;
    logic signed [FIX_W-1:0] r_f  [AXES];
    logic signed [FIX_W-1:0] r_v  [AXES];
    logic signed [FIX_W-1:0] r_r  [AXES];
    logic signed [FIX_W-1:0] r_nv [AXES];
    logic signed [FIX_W-1:0] r_np [AXES];
    logic                    r_last;
    logic [AXIS_W-1:0]       r_axis;
    logic                    r_neg;
    logic signed [FIX_W-1:0] r_vn;
    logic [MAG_W-1:0]        r_mag;
    logic [SQ_W-1:0]         r_sq_sum;
    logic [EPROD_W-1:0]      r_eprod;
    logic [KE_W-1:0]         r_energy;

    logic                    r_out_valid;
    logic signed [FIX_W-1:0] r_out_nv [AXES];
    logic signed [FIX_W-1:0] r_out_np [AXES];
    logic [KE_W-1:0]         r_out_ke;
    logic                    r_out_eos;

    logic                     in_xfer;
    logic                     out_free;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic [DIV_W-1:0]         div_dividend;
    logic [DIV_W-1:0]         div_quotient;
    logic                     div_done;
    logic signed [PROD_W-1:0] prod_abs;

    logic signed [SAT_IN_W-1:0] q_ext;
    logic signed [SAT_IN_W-1:0] vel_sum;
    logic signed [MAG_W-1:0]    speed_sum;
    logic [MAG_W-1:0]           speed_mag;
    logic signed [POS_W-1:0]    pos_step;
    logic signed [SAT_IN_W-1:0] pos_sum;
    logic [KE_W-1:0]            e_term;
    logic [KE_W:0]              e_acc;

    assign in_xfer  = i_in.valid && ctrl.in_ready;
    assign out_free = !r_out_valid || o_out.ready;

    // ---------------- Sequencer ----------------

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in.valid) n_state = S_MUL_DF;
            S_MUL_DF: n_state = S_DIV_LD;
            S_DIV_LD: n_state = S_DIV;
            S_DIV:    if (div_done) n_state = S_VN;
            S_VN:     n_state = S_MUL_DV;
            S_MUL_DV: n_state = S_POS;
            S_POS:    n_state = S_SQ;
            S_SQ:     n_state = (r_axis == AXIS_LAST) ? S_E_LO : S_MUL_DF;
            S_E_LO:   n_state = S_E_HI;
            S_E_HI:   n_state = S_E_ACC;
            S_E_ACC:  n_state = S_E_SUM;
            S_E_SUM:  n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath controls
    always_comb begin
        ctrl = '0;
        ctrl.mul_sel = MS_DT_F;
        unique case (r_state)
            S_IDLE:   ctrl.in_ready  = 1'b1;
            S_MUL_DF: ctrl.mul_sel   = MS_DT_F;
            S_DIV_LD: ctrl.div_start = 1'b1;
            S_DIV:    ctrl.mul_sel   = MS_DT_F;
            S_VN:     ctrl.ld_vn     = 1'b1;
            S_MUL_DV: begin
                ctrl.mul_sel = MS_DT_V;
                ctrl.ld_mag  = 1'b1;
            end
            S_POS: begin
                ctrl.mul_sel = MS_MAG;
                ctrl.ld_pos  = 1'b1;
            end
            S_SQ:     ctrl.ld_sq     = 1'b1;
            S_E_LO:   ctrl.mul_sel   = MS_E_LO;
            S_E_HI: begin
                ctrl.mul_sel = MS_E_HI;
                ctrl.ld_elo  = 1'b1;
            end
            S_E_ACC:  ctrl.ld_eacc   = 1'b1;
            S_E_SUM:  ctrl.ld_esum   = 1'b1;
            S_OUT:    ctrl.ld_out    = out_free;
            default:  ctrl.in_ready  = 1'b0;
        endcase
    end

    // ---------------- Shared units ----------------

    // Multiplier operand select
    always_comb begin
        unique case (ctrl.mul_sel)
            MS_DT_F: begin
                mul_a = MUL_W'(r_time_step);
                mul_b = MUL_W'(r_f[r_axis]);
            end
            MS_DT_V: begin
                mul_a = MUL_W'(r_time_step);
                mul_b = MUL_W'(r_vn);
            end
            MS_MAG: begin
                mul_a = MUL_W'(r_mag);
                mul_b = MUL_W'(r_mag);
            end
            MS_E_LO: begin
                mul_a = MUL_W'(r_mass);
                mul_b = MUL_W'(r_sq_sum[SQ_HALF-1:0]);
            end
            MS_E_HI: begin
                mul_a = MUL_W'(r_mass);
                mul_b = MUL_W'(r_sq_sum[SQ_W-1:SQ_HALF]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lpf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // Divide |dt*f| by mass; sign applied afterwards (truncate toward zero)
    assign prod_abs     = mul_prod[PROD_W-1] ? -mul_prod : mul_prod;
    assign div_dividend = prod_abs[DIV_W-1:0];

    lpf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_mass),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // ---------------- Per-axis arithmetic ----------------

    always_comb begin
        // v' = sat(v + q)
        q_ext     = r_neg ? -$signed({2'b00, div_quotient}) : $signed({2'b00, div_quotient});
        vel_sum   = q_ext + SAT_IN_W'(r_v[r_axis]);
        // |v + v'|
        speed_sum = MAG_W'(r_v[r_axis]) + MAG_W'(r_vn);
        speed_mag = speed_sum[MAG_W-1] ? MAG_W'(-speed_sum) : MAG_W'(speed_sum);
        // r' = sat(r + floor(dt*v' / 2^16))
        pos_step  = mul_prod[POS_MSB:POS_SHIFT];
        pos_sum   = SAT_IN_W'(r_r[r_axis]) + SAT_IN_W'(pos_step);
        // Particle energy term and saturating running sum
        e_term    = (|r_eprod[EPROD_W-1:E_SAT_LSB]) ? KE_MAX
                                                   : r_eprod[E_SAT_LSB-1:E_SHIFT];
        e_acc     = {1'b0, r_energy} + {1'b0, e_term};
    end

    // Control-side registers: time step, energy sum, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
            r_energy    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_time_step <= i_cfg_wr_data;
            end
            if (ctrl.ld_esum) begin
                r_energy <= e_acc[KE_W] ? KE_MAX : e_acc[KE_W-1:0];
            end else if (ctrl.ld_out && r_last) begin
                r_energy <= '0;
            end
            if (ctrl.ld_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mass   <= (i_in.mass == '0) ? FIX_W'(1) : i_in.mass;
            r_f[0]   <= i_in.force_x;
            r_f[1]   <= i_in.force_y;
            r_f[2]   <= i_in.force_z;
            r_v[0]   <= i_in.velocity_x;
            r_v[1]   <= i_in.velocity_y;
            r_v[2]   <= i_in.velocity_z;
            r_r[0]   <= i_in.position_x;
            r_r[1]   <= i_in.position_y;
            r_r[2]   <= i_in.position_z;
            r_last   <= i_in.last_particle;
            r_axis   <= '0;
            r_sq_sum <= '0;
        end
        if (ctrl.div_start) begin
            r_neg <= mul_prod[PROD_W-1];
        end
        if (ctrl.ld_vn) begin
            r_vn <= sat32(vel_sum);
        end
        if (ctrl.ld_mag) begin
            r_mag <= speed_mag;
        end
        if (ctrl.ld_pos) begin
            r_nv[r_axis] <= r_vn;
            r_np[r_axis] <= sat32(pos_sum);
        end
        if (ctrl.ld_sq) begin
            r_sq_sum <= r_sq_sum + SQ_W'(mul_prod[SQ_PROD_W-1:0]);
            r_axis   <= r_axis + 1'b1;
        end
        if (ctrl.ld_elo) begin
            r_eprod <= EPROD_W'(mul_prod[SQ_PROD_W-1:0]);
        end
        if (ctrl.ld_eacc) begin
            r_eprod <= r_eprod + {mul_prod[SQ_PROD_W-1:0], {SQ_HALF{1'b0}}};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (ctrl.ld_out) begin
            for (int k = 0; k < AXES; k++) begin
                r_out_nv[k] <= r_nv[k];
                r_out_np[k] <= r_np[k];
            end
            r_out_ke  <= r_last ? r_energy : '0;
            r_out_eos <= r_last;
        end
    end

    assign i_in.ready           = ctrl.in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.new_velocity_x = r_out_nv[0];
    assign o_out.new_velocity_y = r_out_nv[1];
    assign o_out.new_velocity_z = r_out_nv[2];
    assign o_out.new_position_x = r_out_np[0];
    assign o_out.new_position_y = r_out_np[1];
    assign o_out.new_position_z = r_out_np[2];
    assign o_out.kinetic_total  = r_out_ke;
    assign o_out.end_of_system  = r_out_eos;

endmodule

@@ rtl/core/lpf_chk.sv @@
// ----------------------------------------------------------------------------
// lpf_chk
// Port-level checks for the leapfrog particle core, bound to the top level.
// ----------------------------------------------------------------------------
module lpf_chk
    import lpf_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [FIX_W-1:0] i_out_new_position_x,
    input logic [KE_W-1:0]         i_out_kinetic_total,
    input logic                    i_out_end_of_system
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // One particle at a time: input closes right after a transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // A result never appears just after an input transfer
    a_no_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared right after input transfer");

    // Energy total is only reported on the last particle
    a_ke_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_end_of_system |-> i_out_kinetic_total == '0)
        else $error("nonzero energy total on a non-final particle");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_new_position_x) && $stable(i_out_kinetic_total))
        else $error("stalled result changed");

endmodule

bind leapfrog_particle_update_core lpf_chk u_lpf_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in.valid),
    .i_in_ready           (i_in.ready),
    .i_out_valid          (o_out.valid),
    .i_out_ready          (o_out.ready),
    .i_out_new_position_x (o_out.new_position_x),
    .i_out_kinetic_total  (o_out.kinetic_total),
    .i_out_end_of_system  (o_out.end_of_system)
);
